// ----- rtl/tvof_pkg.sv -----
`timescale 1ns / 1ps

package tvof_pkg;

  // Field widths
  localparam int STAMP_W  = 64;
  localparam int PRICE_W  = 32;
  localparam int VOL_W    = 32;
  localparam int FLAGS_W  = 8;
  localparam int VWAP_W   = 48;
  localparam int TOTAL_W  = 64;
  localparam int SPREAD_W = 33;
  localparam int COUNT_W  = 32;
  localparam int THR_W    = 32;
  localparam int FRAC_W   = 16;

  // Arithmetic widths
  localparam int MUL_W = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = VWAP_W + TOTAL_W + 1;
  localparam int DEN_W = TOTAL_W + 1;
  localparam int RHS_W = THR_W + VWAP_W;
  localparam int DIV_STEPS = VWAP_W;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Tick flag bits
  localparam logic [FLAGS_W-1:0] FLAG_BID = 8'h01;
  localparam logic [FLAGS_W-1:0] FLAG_ASK = 8'h02;

  // Partial product counts (last step index) per multiply phase
  localparam logic [2:0] THR_LAST = 3'd1;
  localparam logic [2:0] NUM_LAST = 3'd4;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_OUT_OF_ORDER = 2'd1,
    ST_OUTLIER      = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_VWAP_EN   = 2'd1,
    CFG_SPREAD_EN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32,
    SH_64
  } mac_shift_t;

  typedef struct packed {
    logic             clear;
    logic             issue;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    mac_shift_t       shift;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_THR,
    S_OCMP,
    S_PASS,
    S_NUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/tvof_mac.sv -----
`timescale 1ns / 1ps

// Shared 32x32 multiplier with registered product and shifted accumulate.
module tvof_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  tvof_pkg::mac_ctrl_t         ctrl,
  output logic [tvof_pkg::ACC_W-1:0]  acc
);

  logic                         pvalid;
  logic [tvof_pkg::PROD_W-1:0]  prod;
  tvof_pkg::mac_shift_t         pshift;
  logic [tvof_pkg::ACC_W-1:0]   prod_ext;
  logic [tvof_pkg::ACC_W-1:0]   addend;

  // Place the product at its partial-product weight
  always_comb begin
    prod_ext = tvof_pkg::ACC_W'(prod);
    case (pshift)
      tvof_pkg::SH_0:  addend = prod_ext;
      tvof_pkg::SH_16: addend = prod_ext << 16;
      tvof_pkg::SH_32: addend = prod_ext << 32;
      tvof_pkg::SH_64: addend = prod_ext << 64;
      default:         addend = prod_ext;
    endcase
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctrl.issue & ~ctrl.clear;
    end
    prod   <= ctrl.a * ctrl.b;
    pshift <= ctrl.shift;
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (pvalid) begin
      acc <= acc + addend;
    end
  end

endmodule

// ----- rtl/tvof_div.sv -----
`timescale 1ns / 1ps

// Radix-2 restoring divider. The quotient is known to fit VWAP_W bits, so the
// partial remainder starts from the numerator's top bits.
module tvof_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tvof_pkg::ACC_W-1:0]   num,
  input  logic [tvof_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [tvof_pkg::VWAP_W-1:0]  quot
);

  localparam int CNT_W = $clog2(tvof_pkg::DIV_STEPS + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [tvof_pkg::DEN_W-1:0]    rem;
  logic [tvof_pkg::DEN_W-1:0]    dvs;
  logic [tvof_pkg::VWAP_W-1:0]   low_bits;
  logic [tvof_pkg::DEN_W:0]      trial;
  logic [tvof_pkg::DEN_W:0]      diff;
  logic                          fits;

  // One compare-subtract per cycle
  always_comb begin
    trial = {rem, low_bits[tvof_pkg::VWAP_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(tvof_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num[tvof_pkg::ACC_W-1:tvof_pkg::VWAP_W];
      low_bits <= num[tvof_pkg::VWAP_W-1:0];
      dvs      <= den;
      quot     <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[tvof_pkg::DEN_W-1:0] : trial[tvof_pkg::DEN_W-1:0];
      low_bits <= {low_bits[tvof_pkg::VWAP_W-2:0], 1'b0};
      quot     <= {quot[tvof_pkg::VWAP_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/tick_vwap_outlier_filter.sv -----
`timescale 1ns / 1ps
// Path per item: out-of-order items go straight to the result; otherwise a nonzero
// vwap is checked by a threshold multiply and compare (outliers end there), and an
// accepted item may recompute the vwap with the 5-pass numerator multiply and the
// 48-step radix-2 divider. One item at a time: in_stall holds off the next item.
// A result waits in the output register while the next item is taken.
// Reset (rst, synchronous) clears the FSM, the filter state, config registers and the output valid.
module tick_vwap_outlier_filter (
  input  logic                                clk,
  input  logic                                rst,
  // Tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tvof_pkg::STAMP_W-1:0]        stamp,
  input  logic [tvof_pkg::PRICE_W-1:0]        price,
  input  logic [tvof_pkg::VOL_W-1:0]          volume,
  input  logic [tvof_pkg::FLAGS_W-1:0]        tick_flags,
  // Result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [tvof_pkg::VWAP_W-1:0]         vwap_now,
  output logic [tvof_pkg::TOTAL_W-1:0]        total_vol,
  output logic signed [tvof_pkg::SPREAD_W-1:0] spread_now,
  output logic [tvof_pkg::COUNT_W-1:0]        outliers,
  // Config write port
  input  logic                                cfg_wr_en,
  input  logic [tvof_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tvof_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tvof_pkg::state_t state, state_next;

  // Config
  logic [tvof_pkg::THR_W-1:0]   threshold;
  logic                         vwap_en;
  logic                         spread_en;

  // Latched item
  logic [tvof_pkg::STAMP_W-1:0] cur_stamp;
  logic [tvof_pkg::PRICE_W-1:0] cur_price;
  logic [tvof_pkg::VOL_W-1:0]   cur_volume;
  logic                         cur_bid;
  logic                         cur_ask;

  // Filter state
  logic [tvof_pkg::STAMP_W-1:0]  last_stamp;
  logic [tvof_pkg::VWAP_W-1:0]   running_vwap;
  logic [tvof_pkg::TOTAL_W-1:0]  volume_sum;
  logic [tvof_pkg::PRICE_W-1:0]  best_bid;
  logic [tvof_pkg::PRICE_W-1:0]  best_ask;
  logic [tvof_pkg::SPREAD_W-1:0] spread_reg;
  logic [tvof_pkg::COUNT_W-1:0]  outlier_total;

  // Work registers
  tvof_pkg::status_t             res_status;
  logic [2:0]                    step;
  logic [tvof_pkg::VWAP_W-1:0]   dev;
  logic [tvof_pkg::DEN_W-1:0]    den;

  // Shared units
  tvof_pkg::mac_ctrl_t           mac_ctrl;
  logic [tvof_pkg::ACC_W-1:0]    acc;
  logic                          div_start;
  logic                          div_done;
  logic [tvof_pkg::VWAP_W-1:0]   div_quot;

  // Combinational helpers
  logic                          in_accept;
  logic                          out_load;
  logic                          stamp_later;
  logic [tvof_pkg::VWAP_W-1:0]   price_q;
  logic                          is_outlier;
  logic                          den_zero;
  logic [tvof_pkg::DEN_W-1:0]    sum_ext;
  logic [tvof_pkg::PRICE_W-1:0]  bid_next;
  logic [tvof_pkg::PRICE_W-1:0]  ask_next;

  assign in_stall  = (state != tvof_pkg::S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_load  = (state == tvof_pkg::S_DONE) & (~out_valid | ~out_stall);

  assign stamp_later = cur_stamp > last_stamp;
  assign price_q     = {cur_price, {tvof_pkg::FRAC_W{1'b0}}};
  assign is_outlier  = {{tvof_pkg::FRAC_W{1'b0}}, dev, {tvof_pkg::FRAC_W{1'b0}}} >
                       acc[tvof_pkg::RHS_W-1:0];
  assign den_zero    = (volume_sum == '0) & (cur_volume == '0);
  assign sum_ext     = {1'b0, volume_sum} + tvof_pkg::DEN_W'(cur_volume);
  assign bid_next    = cur_bid ? cur_price : best_bid;
  assign ask_next    = cur_ask ? cur_price : best_ask;

  tvof_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .acc  (acc)
  );

  tvof_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tvof_pkg::S_IDLE: begin
        if (in_accept) state_next = tvof_pkg::S_CHECK;
      end
      tvof_pkg::S_CHECK: begin
        if (!stamp_later)              state_next = tvof_pkg::S_DONE;
        else if (running_vwap == '0)   state_next = tvof_pkg::S_PASS;
        else                           state_next = tvof_pkg::S_THR;
      end
      tvof_pkg::S_THR: begin
        if (step == tvof_pkg::THR_LAST + 3'd1) state_next = tvof_pkg::S_OCMP;
      end
      tvof_pkg::S_OCMP: begin
        state_next = is_outlier ? tvof_pkg::S_DONE : tvof_pkg::S_PASS;
      end
      tvof_pkg::S_PASS: begin
        if (vwap_en && !den_zero) state_next = tvof_pkg::S_NUM;
        else                      state_next = tvof_pkg::S_UPDATE;
      end
      tvof_pkg::S_NUM: begin
        if (step == tvof_pkg::NUM_LAST + 3'd1) state_next = tvof_pkg::S_DIV_START;
      end
      tvof_pkg::S_DIV_START: state_next = tvof_pkg::S_DIV_WAIT;
      tvof_pkg::S_DIV_WAIT: begin
        if (div_done) state_next = tvof_pkg::S_UPDATE;
      end
      tvof_pkg::S_UPDATE: state_next = tvof_pkg::S_DONE;
      tvof_pkg::S_DONE: begin
        if (out_load) state_next = tvof_pkg::S_IDLE;
      end
      default: state_next = tvof_pkg::S_IDLE;
    endcase
  end

  // Unit control: operand schedule for the multiplier, divider start
  always_comb begin
    mac_ctrl       = '0;
    mac_ctrl.shift = tvof_pkg::SH_0;
    div_start      = 1'b0;
    unique case (state)
      tvof_pkg::S_CHECK, tvof_pkg::S_PASS: begin
        mac_ctrl.clear = 1'b1;
      end
      // threshold * vwap
      tvof_pkg::S_THR: begin
        mac_ctrl.issue = (step <= tvof_pkg::THR_LAST);
        mac_ctrl.a     = threshold;
        case (step)
          3'd0: begin
            mac_ctrl.b     = running_vwap[31:0];
            mac_ctrl.shift = tvof_pkg::SH_0;
          end
          default: begin
            mac_ctrl.b     = 32'(running_vwap[tvof_pkg::VWAP_W-1:32]);
            mac_ctrl.shift = tvof_pkg::SH_32;
          end
        endcase
      end
      // vwap * volume_sum + (price * volume) << 16
      tvof_pkg::S_NUM: begin
        mac_ctrl.issue = (step <= tvof_pkg::NUM_LAST);
        case (step)
          3'd0: begin
            mac_ctrl.a     = running_vwap[31:0];
            mac_ctrl.b     = volume_sum[31:0];
            mac_ctrl.shift = tvof_pkg::SH_0;
          end
          3'd1: begin
            mac_ctrl.a     = running_vwap[31:0];
            mac_ctrl.b     = volume_sum[63:32];
            mac_ctrl.shift = tvof_pkg::SH_32;
          end
          3'd2: begin
            mac_ctrl.a     = 32'(running_vwap[tvof_pkg::VWAP_W-1:32]);
            mac_ctrl.b     = volume_sum[31:0];
            mac_ctrl.shift = tvof_pkg::SH_32;
          end
          3'd3: begin
            mac_ctrl.a     = 32'(running_vwap[tvof_pkg::VWAP_W-1:32]);
            mac_ctrl.b     = volume_sum[63:32];
            mac_ctrl.shift = tvof_pkg::SH_64;
          end
          default: begin
            mac_ctrl.a     = cur_price;
            mac_ctrl.b     = cur_volume;
            mac_ctrl.shift = tvof_pkg::SH_16;
          end
        endcase
      end
      tvof_pkg::S_DIV_START: begin
        div_start = 1'b1;
      end
      default: begin
        mac_ctrl.clear = 1'b0;
      end
    endcase
  end

  // State register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvof_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == tvof_pkg::S_THR || state == tvof_pkg::S_NUM) step <= step + 3'd1;
      else step <= '0;
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      vwap_en   <= 1'b0;
      spread_en <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (tvof_pkg::cfg_idx_t'(cfg_addr))
        tvof_pkg::CFG_THRESHOLD: threshold <= cfg_wdata[tvof_pkg::THR_W-1:0];
        tvof_pkg::CFG_VWAP_EN:   vwap_en   <= cfg_wdata[0];
        tvof_pkg::CFG_SPREAD_EN: spread_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Item capture and per-item work registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_stamp  <= stamp;
      cur_price  <= price;
      cur_volume <= volume;
      cur_bid    <= |(tick_flags & tvof_pkg::FLAG_BID);
      cur_ask    <= |(tick_flags & tvof_pkg::FLAG_ASK);
    end
    if (state == tvof_pkg::S_CHECK) begin
      dev <= (price_q >= running_vwap) ? price_q - running_vwap : running_vwap - price_q;
    end
    if (state == tvof_pkg::S_PASS) begin
      den <= sum_ext;
    end
  end

  // Filter state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp    <= '0;
      running_vwap  <= '0;
      volume_sum    <= '0;
      best_bid      <= '0;
      best_ask      <= '0;
      spread_reg    <= '0;
      outlier_total <= '0;
      res_status    <= tvof_pkg::ST_ACCEPTED;
    end else begin
      unique case (state)
        tvof_pkg::S_CHECK: begin
          if (!stamp_later) res_status <= tvof_pkg::ST_OUT_OF_ORDER;
        end
        tvof_pkg::S_OCMP: begin
          if (is_outlier) begin
            res_status <= tvof_pkg::ST_OUTLIER;
            if (outlier_total != '1) outlier_total <= outlier_total + 1'b1;
          end
        end
        tvof_pkg::S_DIV_WAIT: begin
          if (div_done) running_vwap <= div_quot;
        end
        tvof_pkg::S_UPDATE: begin
          res_status <= tvof_pkg::ST_ACCEPTED;
          volume_sum <= sum_ext[tvof_pkg::TOTAL_W] ? '1 : sum_ext[tvof_pkg::TOTAL_W-1:0];
          last_stamp <= cur_stamp;
          if (spread_en) begin
            best_bid <= bid_next;
            best_ask <= ask_next;
            if (bid_next != '0 && ask_next != '0) begin
              spread_reg <= {1'b0, ask_next} - {1'b0, bid_next};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      vwap_now   <= running_vwap;
      total_vol  <= volume_sum;
      spread_now <= spread_reg;
      outliers   <= outlier_total;
    end
  end

endmodule
